[design/assert_macros.svh]
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define JHB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define JHB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[design/jhb_pkg.sv]
`default_nettype none
package jhb_pkg;

   // Field widths
   localparam int KEY_W   = 64;
   localparam int COUNT_W = 31;

   // Linear congruential step: key = key * LCG_MULT + 1
   localparam logic [KEY_W-1:0] LCG_MULT = 64'h27BB_2EE6_87B0_B0FD;
   localparam int MUL_CNT_W = 6;

   // Jump division: ((b + 1) << 31) / ((key >> 33) + 1)
   localparam int KEY_SHIFT = 33;
   localparam int NUM_W     = COUNT_W + 31;
   localparam int DIV_W     = KEY_W - KEY_SHIFT + 1;
   localparam int DIV_CNT_W = 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } jhb_state_type;

   typedef struct packed {
      logic ready;
      logic mul_start;
      logic div_start;
      logic rsp_load;
   } jhb_ctl_type;

endpackage
`default_nettype wire

[design/jhb_channels.sv]
`default_nettype none
interface jhb_req_if;
   import jhb_pkg::*;
   logic               valid;
   logic               ready;
   logic [KEY_W-1:0]   key_hash;

   modport source (output valid, output key_hash, input ready);
   modport sink   (input valid, input key_hash, output ready);
endinterface

interface jhb_rsp_if;
   import jhb_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] bucket_index;
   logic               no_buckets;

   modport source (output valid, output bucket_index, output no_buckets, input ready);
   modport sink   (input valid, input bucket_index, input no_buckets, output ready);
endinterface
`default_nettype wire

[design/jhb_lcg_step.sv]
`default_nettype none
module jhb_lcg_step (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [jhb_pkg::KEY_W-1:0]  key_in,
   output logic                       done,
   output logic [jhb_pkg::KEY_W-1:0]  key_out
);
   import jhb_pkg::*;

   localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(KEY_W - 1);

   logic                 active_ff;
   logic                 done_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic [KEY_W-1:0]     mcand_ff;
   logic [KEY_W-1:0]     mplier_ff;
   logic [KEY_W-1:0]     acc_ff;

   // Sequence one multiplier bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            cnt_ff    <= '0;
         end else if (active_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   // Shift-and-add, modulo 2^64; accumulator starts at the +1 term
   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff  <= key_in;
         mplier_ff <= LCG_MULT;
         acc_ff    <= KEY_W'(1);
      end else if (active_ff) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[KEY_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[KEY_W-1:1]};
      end
   end

   assign done    = done_ff;
   assign key_out = acc_ff;

endmodule
`default_nettype wire

[design/jhb_jump_div.sv]
`default_nettype none
module jhb_jump_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [jhb_pkg::COUNT_W-1:0]  b_plus_one,
   input  logic [jhb_pkg::KEY_W-1:0]    key_in,
   output logic                         done,
   output logic [jhb_pkg::NUM_W-1:0]    quotient
);
   import jhb_pkg::*;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

   logic                 active_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0]     num_ff;
   logic [DIV_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     divisor_ff;
   logic [DIV_W:0]       shifted;
   logic [DIV_W:0]       trial;

   // Sequence one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            cnt_ff    <= '0;
         end else if (active_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   // Restoring step: shift in the next dividend bit, subtract when it fits
   always_comb begin
      shifted = {rem_ff, num_ff[NUM_W-1]};
      trial   = shifted - {1'b0, divisor_ff};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff     <= {b_plus_one, (NUM_W - COUNT_W)'(0)};
         rem_ff     <= '0;
         divisor_ff <= {1'b0, key_in[KEY_W-1:KEY_SHIFT]} + 1'b1;
      end else if (active_ff) begin
         if (trial[DIV_W]) begin
            rem_ff <= shifted[DIV_W-1:0];
            num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         end else begin
            rem_ff <= trial[DIV_W-1:0];
            num_ff <= {num_ff[NUM_W-2:0], 1'b1};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule
`default_nettype wire

[design/jump_hash_bucket_select.sv]
// Jump consistent hash bucket select, one item at a time.
// With zero buckets no jump is run; otherwise each jump runs a bit-serial LCG multiply
// and then a restoring divide, and the result goes to the output register at the end.
// Jumps per item average ln(bucket_count) + 1; the next item is taken the cycle after the
// result is loaded into the output register, and none is taken while an item is in flight.
// Reset (synchronous, active high) clears bucket_count, the sequencer and the output valid.
`default_nettype none
module jump_hash_bucket_select (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [jhb_pkg::COUNT_W-1:0] csr_wr_data,
   jhb_req_if.sink                     req_ch,
   jhb_rsp_if.source                   rsp_ch
);
   import jhb_pkg::*;

   `include "assert_macros.svh"

   jhb_state_type        state_ff;
   jhb_state_type        state_in;
   jhb_ctl_type          ctl;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   b_ff;
   logic                 empty_ff;
   logic                 rsp_valid_ff;
   logic [COUNT_W-1:0]   rsp_bucket_ff;
   logic                 rsp_empty_ff;
   logic                 req_fire;
   logic                 out_free;
   logic                 count_zero;
   logic                 jump_below;
   logic                 rsp_in_range;
   logic                 mul_done;
   logic                 div_done;
   logic [KEY_W-1:0]     mul_key_in;
   logic [KEY_W-1:0]     lcg_key;
   logic [NUM_W-1:0]     jump;

   // Bucket count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   assign req_fire   = req_ch.valid && ctl.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign count_zero = (count_ff == '0);
   assign jump_below = (jump[NUM_W-1:COUNT_W] == '0) && (jump[COUNT_W-1:0] < count_ff);

   // First step takes the incoming key, later steps chain the last one
   assign mul_key_in = (state_ff == ST_IDLE) ? req_ch.key_hash : lcg_key;

   jhb_lcg_step u_lcg (
      .clock   (clock),
      .reset   (reset),
      .start   (ctl.mul_start),
      .key_in  (mul_key_in),
      .done    (mul_done),
      .key_out (lcg_key)
   );

   jhb_jump_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (ctl.div_start),
      .b_plus_one (b_ff + 1'b1),
      .key_in     (lcg_key),
      .done       (div_done),
      .quotient   (jump)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = count_zero ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = jump_below ? ST_MUL : ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.ready     = 1'b1;
            ctl.mul_start = req_ch.valid && !count_zero;
         end
         ST_MUL: begin
            ctl.div_start = mul_done;
         end
         ST_DIV: begin
            ctl.mul_start = div_done && jump_below;
         end
         ST_DONE: begin
            ctl.rsp_load = out_free;
         end
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Track the last candidate below the bucket count
   always_ff @(posedge clock) begin
      if (req_fire) begin
         b_ff     <= '0;
         empty_ff <= count_zero;
      end else if (state_ff == ST_DIV && div_done && jump_below) begin
         b_ff <= jump[COUNT_W-1:0];
      end
   end

   // Output register; frees the sequencer while the item waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_bucket_ff <= b_ff;
         rsp_empty_ff  <= empty_ff;
      end
   end

   assign req_ch.ready        = ctl.ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.bucket_index = rsp_bucket_ff;
   assign rsp_ch.no_buckets   = rsp_empty_ff;

   assign rsp_in_range = (rsp_bucket_ff < count_ff);

   `JHB_ASSERT(a_mul_done_in_mul, mul_done |-> state_ff == ST_MUL, "multiply finished outside MUL")
   `JHB_ASSERT(a_div_done_in_div, div_done |-> state_ff == ST_DIV, "divide finished outside DIV")
   `JHB_ASSERT(a_bucket_below, rsp_valid_ff && !rsp_empty_ff |-> rsp_in_range, "bucket too high")
   `JHB_ASSERT_ALWAYS(a_ready_only_idle, req_ch.ready |-> state_ff == ST_IDLE, "ready not in IDLE")

endmodule
`default_nettype wire
